// ===== design/tsoa_pkg.sv =====
// Shared types and constants for the two-stacks-in-one-array block.
package tsoa_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_LOW  = 3'd0,
        OP_PUSH_HIGH = 3'd1,
        OP_POP_LOW   = 3'd2,
        OP_POP_HIGH  = 3'd3,
        OP_LIST_LOW  = 3'd4,
        OP_LIST_HIGH = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

    typedef struct packed {
        logic    push_low;
        logic    push_high;
        logic    pop_low;
        logic    pop_high;
        logic    list_start;
        logic    list_step;
        logic    list_high;
        logic    emit;
        t_status emit_status;
        logic    emit_last;
        logic    emit_ram;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic low_empty;
        logic high_empty;
        logic low_one;
        logic high_one;
        logic pos_one;
    } t_flags;

endpackage

// ===== design/two_stacks_one_array_core.sv =====
// Two LIFO stacks sharing one store: top level.
// Push and pop: result appears the cycle after the transfer, busy stays low.
// List of n elements: n results on consecutive cycles, the first in the cycle after the transfer;
// busy is high while the single read port of the store walks the stack.
// Results cannot be stalled; o_valid marks each one for one cycle.
// Synchronous active-low reset empties both stacks; store contents are not cleared.
module two_stacks_one_array_core #(
    parameter int DEPTH = tsoa_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [tsoa_pkg::OP_W-1:0]          i_operation,
    input  logic signed [tsoa_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    output logic [tsoa_pkg::STATUS_W-1:0]      o_status,
    output logic signed [tsoa_pkg::DATA_W-1:0] o_data,
    output logic                               o_last
);
    import tsoa_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    tsoa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    tsoa_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (cmd),
        .o_flags  (flags),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_data   (o_data),
        .o_last   (o_last)
    );

endmodule

// ===== design/tsoa_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tsoa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tsoa_ctrl.sv =====
// Control FSM: decodes transfers and sequences list reads.
module tsoa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tsoa_pkg::OP_W-1:0]   i_operation,
    input  tsoa_pkg::t_flags            i_flags,
    output tsoa_pkg::t_cmd              o_cmd
);
    import tsoa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_LIST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_LIST_LOW && !i_flags.low_empty
                        && !i_flags.low_one) begin
                        n_state = S_LIST;
                    end
                    if (i_operation == OP_LIST_HIGH && !i_flags.high_empty
                        && !i_flags.high_one) begin
                        n_state = S_LIST;
                    end
                end
            end
            S_LIST: begin
                if (i_flags.pos_one) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.emit_status = STAT_OK;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        OP_PUSH_LOW, OP_PUSH_HIGH: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_flags.full) begin
                                o_cmd.emit_status = STAT_OVERFLOW;
                            end else begin
                                o_cmd.push_low  = (i_operation == OP_PUSH_LOW);
                                o_cmd.push_high = (i_operation == OP_PUSH_HIGH);
                            end
                        end
                        OP_POP_LOW: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_flags.low_empty) begin
                                o_cmd.emit_status = STAT_UNDERFLOW;
                            end else begin
                                o_cmd.pop_low = 1'b1;
                            end
                        end
                        OP_POP_HIGH: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_flags.high_empty) begin
                                o_cmd.emit_status = STAT_UNDERFLOW;
                            end else begin
                                o_cmd.pop_high = 1'b1;
                            end
                        end
                        OP_LIST_LOW: begin
                            o_cmd.emit = 1'b1;
                            if (i_flags.low_empty) begin
                                o_cmd.emit_status = STAT_EMPTY;
                                o_cmd.emit_last   = 1'b1;
                            end else begin
                                o_cmd.list_start = 1'b1;
                                o_cmd.emit_ram   = 1'b1;
                                o_cmd.emit_last  = i_flags.low_one;
                            end
                        end
                        OP_LIST_HIGH: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.list_high = 1'b1;
                            if (i_flags.high_empty) begin
                                o_cmd.emit_status = STAT_EMPTY;
                                o_cmd.emit_last   = 1'b1;
                            end else begin
                                o_cmd.list_start = 1'b1;
                                o_cmd.emit_ram   = 1'b1;
                                o_cmd.emit_last  = i_flags.high_one;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LIST: begin
                o_cmd.list_step = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_ram  = 1'b1;
                o_cmd.emit_last = i_flags.pos_one;
            end
            default: ;
        endcase
    end

endmodule

// ===== design/tsoa_datapath.sv =====
// Datapath: stack counts, address generation, shared store and result registers.
module tsoa_datapath #(
    parameter int DEPTH = tsoa_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [tsoa_pkg::DATA_W-1:0] i_value,
    input  tsoa_pkg::t_cmd                    i_cmd,
    output tsoa_pkg::t_flags                  o_flags,
    output logic                              o_valid,
    output logic [tsoa_pkg::STATUS_W-1:0]     o_status,
    output logic signed [tsoa_pkg::DATA_W-1:0] o_data,
    output logic                              o_last
);
    import tsoa_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [CW-1:0]     r_cnt_low;
    logic [CW-1:0]     r_cnt_high;
    logic [CW-1:0]     r_pos;
    logic              r_sel_high;
    logic              r_valid;
    t_status           r_status;
    logic              r_last;
    logic              r_from_ram;

    logic [CW:0]       sum;
    logic              sel_high;
    logic [CW-1:0]     pos;
    logic [CW-1:0]     rd_full;
    logic [CW-1:0]     wr_full;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic              we;
    logic [DATA_W-1:0] ram_q;

    assign sum = {1'b0, r_cnt_low} + {1'b0, r_cnt_high};

    assign o_flags.full       = (sum >= {1'b0, DEPTH_C});
    assign o_flags.low_empty  = (r_cnt_low == '0);
    assign o_flags.high_empty = (r_cnt_high == '0);
    assign o_flags.low_one    = (r_cnt_low == ONE_C);
    assign o_flags.high_one   = (r_cnt_high == ONE_C);
    assign o_flags.pos_one    = (r_pos == ONE_C);

    assign sel_high = i_cmd.list_start ? i_cmd.list_high : r_sel_high;

    always_comb begin
        if (i_cmd.list_start) begin
            pos = i_cmd.list_high ? r_cnt_high : r_cnt_low;
        end else begin
            pos = r_pos;
        end
    end

    assign rd_full = sel_high ? (DEPTH_C - pos) : (pos - ONE_C);
    assign raddr   = rd_full[AW-1:0];
    assign wr_full = i_cmd.push_high ? (DEPTH_C - r_cnt_high - ONE_C) : r_cnt_low;
    assign waddr   = wr_full[AW-1:0];
    assign we      = i_cmd.push_low || i_cmd.push_high;

    tsoa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_low  <= '0;
            r_cnt_high <= '0;
            r_pos      <= '0;
            r_sel_high <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.push_low) begin
                r_cnt_low <= r_cnt_low + ONE_C;
            end else if (i_cmd.pop_low) begin
                r_cnt_low <= r_cnt_low - ONE_C;
            end
            if (i_cmd.push_high) begin
                r_cnt_high <= r_cnt_high + ONE_C;
            end else if (i_cmd.pop_high) begin
                r_cnt_high <= r_cnt_high - ONE_C;
            end
            if (i_cmd.list_start || i_cmd.list_step) begin
                r_pos <= pos - ONE_C;
            end
            if (i_cmd.list_start) begin
                r_sel_high <= i_cmd.list_high;
            end
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= i_cmd.emit_status;
        r_last     <= i_cmd.emit_last;
        r_from_ram <= i_cmd.emit_ram;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_last   = r_last;
    assign o_data   = r_from_ram ? signed'(ram_q) : '0;

    a_no_overcommit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum <= {1'b0, DEPTH_C})
        else $error("stack counts exceed store depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_low |=> r_cnt_low == $past(r_cnt_low) + ONE_C)
        else $error("push did not advance lower stack");

    a_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_from_ram |-> r_status == STAT_OK)
        else $error("listed element with non-ok status");

    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.list_step |-> r_pos != '0)
        else $error("list step past bottom of stack");

endmodule

// ===== tb/tsoa_stack_check.sv =====
// Result checker for the two-stacks-in-one-array core: tracks both stacks and compares every result.
module tsoa_stack_check #(
    parameter int DEPTH = tsoa_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [tsoa_pkg::OP_W-1:0]        i_operation,
    input  logic [tsoa_pkg::DATA_W-1:0]      i_value,
    input  logic                             i_valid,
    input  logic [tsoa_pkg::STATUS_W-1:0]    i_status,
    input  logic [tsoa_pkg::DATA_W-1:0]      i_data,
    input  logic                             i_last,
    output int                               o_fail_count,
    output int                               o_pending
);
    import tsoa_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_stack_result;

    t_stack_result     pending_results[$];
    logic [DATA_W-1:0] word_store[DEPTH];
    int unsigned       depth_low;
    int unsigned       depth_high;
    int                mismatches = 0;

    task automatic queue_result(input t_status status, input logic [DATA_W-1:0] data,
                                input logic last);
        t_stack_result r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        pending_results.push_back(r);
    endtask

    task automatic apply_stack_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
        int unsigned k;
        case (op)
            OP_PUSH_LOW: begin
                if (depth_low + depth_high >= DEPTH) begin
                    queue_result(STAT_OVERFLOW, '0, 1'b1);
                end else begin
                    word_store[depth_low] = word;
                    depth_low++;
                    queue_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_PUSH_HIGH: begin
                if (depth_low + depth_high >= DEPTH) begin
                    queue_result(STAT_OVERFLOW, '0, 1'b1);
                end else begin
                    depth_high++;
                    word_store[DEPTH - depth_high] = word;
                    queue_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_POP_LOW: begin
                if (depth_low == 0) begin
                    queue_result(STAT_UNDERFLOW, '0, 1'b1);
                end else begin
                    depth_low--;
                    queue_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_POP_HIGH: begin
                if (depth_high == 0) begin
                    queue_result(STAT_UNDERFLOW, '0, 1'b1);
                end else begin
                    depth_high--;
                    queue_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_LIST_LOW: begin
                if (depth_low == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (k = depth_low; k > 0; k--)
                        queue_result(STAT_OK, word_store[k-1], k == 1);
                end
            end
            OP_LIST_HIGH: begin
                if (depth_high == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (k = depth_high; k > 0; k--)
                        queue_result(STAT_OK, word_store[DEPTH - k], k == 1);
                end
            end
            default: ;  // unused codes: no result
        endcase
    endtask

    task automatic check_result();
        t_stack_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d data %h last %0b", i_status, i_data, i_last);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            if (i_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, i_status);
                mismatches++;
            end
            if (i_data !== want.data) begin
                $error("data: expected %h, got %h", want.data, i_data);
                mismatches++;
            end
            if (i_last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, i_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_low  = 0;
            depth_high = 0;
            pending_results.delete();
        end else begin
            // results belong to earlier transfers, so check before predicting
            if (i_valid !== 1'b0)
                check_result();
            if (i_start && !i_busy)
                apply_stack_op(i_operation, i_value);
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/two_stacks_one_array_core_tb.sv =====
// Testbench top for the two-stacks-in-one-array core: stimulus, idle patterns and verdict.
module two_stacks_one_array_core_tb;
    import tsoa_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
    localparam int PHASE_ITEMS = 120;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic [OP_W-1:0]          i_operation = '0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     busy;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;
    int                       fail_count;
    int                       pending;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    two_stacks_one_array_core #(.DEPTH(DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    tsoa_stack_check #(.DEPTH(DEPTH)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_data       (o_data),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // hold start low until every predicted result has come out
    task automatic drain_hold();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic transfer(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word,
                            input int idle_pct);
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= word;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < 2) begin
            drain_hold();
        end else if ($urandom_range(99) < idle_pct) begin
            start       <= 1'b0;
            i_operation <= OP_W'($urandom);
            i_value     <= $urandom;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic run_phase(input int idle_pct);
        int done;
        int pick;
        logic side;
        done = 0;
        while (done < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // fill until the tops meet, with the surplus pushes refused
                repeat (DEPTH + 2) begin
                    side = 1'($urandom_range(1));
                    transfer(side ? OP_PUSH_HIGH : OP_PUSH_LOW, rand_word(), idle_pct);
                end
                transfer(OP_LIST_LOW, rand_word(), idle_pct);
                transfer(OP_LIST_HIGH, rand_word(), idle_pct);
                done += DEPTH + 4;
            end else if (pick < 11) begin
                // empty one side past the bottom
                side = 1'($urandom_range(1));
                repeat (DEPTH + 1)
                    transfer(side ? OP_POP_HIGH : OP_POP_LOW, rand_word(), idle_pct);
                transfer(side ? OP_LIST_HIGH : OP_LIST_LOW, rand_word(), idle_pct);
                done += DEPTH + 2;
            end else begin
                pick = $urandom_range(99);
                side = 1'($urandom_range(1));
                if (pick < 38) begin
                    transfer(side ? OP_PUSH_HIGH : OP_PUSH_LOW, rand_word(), idle_pct);
                    done++;
                end else if (pick < 64) begin
                    transfer(side ? OP_POP_HIGH : OP_POP_LOW, rand_word(), idle_pct);
                    done++;
                end else if (pick < 94) begin
                    transfer(side ? OP_LIST_HIGH : OP_LIST_LOW, rand_word(), idle_pct);
                    done++;
                end else begin
                    transfer(side ? OP_UNUSED_B : OP_UNUSED_A, rand_word(), idle_pct);
                end
            end
        end
        drain_hold();
    endtask

    initial begin
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty stacks, unused codes, extreme words, every operation
        transfer(OP_POP_LOW, 32'hFFFF_FFFF, 0);
        transfer(OP_POP_HIGH, 32'h0000_0000, 0);
        transfer(OP_LIST_LOW, 32'h0000_0000, 0);
        transfer(OP_LIST_HIGH, 32'hFFFF_FFFF, 0);
        transfer(OP_UNUSED_A, 32'h1234_5678, 0);
        transfer(OP_UNUSED_B, 32'hFFFF_FFFF, 0);
        transfer(OP_PUSH_LOW, 32'h8000_0000, 0);
        transfer(OP_PUSH_LOW, 32'h7FFF_FFFF, 0);
        transfer(OP_PUSH_HIGH, 32'h0000_0000, 0);
        transfer(OP_PUSH_HIGH, 32'hFFFF_FFFF, 0);
        transfer(OP_PUSH_LOW, 32'h5555_5555, 0);
        transfer(OP_PUSH_HIGH, 32'hAAAA_AAAA, 0);
        transfer(OP_LIST_LOW, 32'h0000_0000, 0);
        transfer(OP_LIST_HIGH, 32'h0000_0000, 0);
        transfer(OP_POP_LOW, 32'h0000_0000, 0);
        transfer(OP_POP_HIGH, 32'h0000_0000, 0);
        transfer(OP_LIST_LOW, 32'h0000_0000, 0);
        transfer(OP_LIST_HIGH, 32'h0000_0000, 0);
        drain_hold();

        run_phase(38);
        run_phase(85);
        run_phase(0);

        start <= 1'b0;
        @(posedge i_clk);
        for (k = 0; k < 500 && pending != 0; k++)
            @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (pending != 0)
            $error("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(12 * 600_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tsoa_pkg.sv
design/tsoa_ram.sv
design/tsoa_ctrl.sv
design/tsoa_datapath.sv
design/two_stacks_one_array_core.sv
tb/tsoa_stack_check.sv
tb/two_stacks_one_array_core_tb.sv
